// ===== rtl/core/clamped_piecewise_linear_lookup_unit_macros.svh =====
// Assertion macros shared by the lookup unit's RTL files.
// Defining NO_ASSERTIONS turns every use into nothing; no other dependencies.
`ifndef CLAMPED_PIECEWISE_LINEAR_LOOKUP_UNIT_MACROS_SVH
`define CLAMPED_PIECEWISE_LINEAR_LOOKUP_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// A property checked on every rising edge outside reset.
`define CPLL_ASSERT(label, c, r, prop, msg) \
    label: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);
// A condition that must be followed by a consequence in the next cycle.
`define CPLL_ASSERT_NEXT(label, c, r, cond, conseq, msg) \
    label: assert property (@(posedge c) disable iff (!r) (cond) |=> (conseq)) else $error(msg);
`else
`define CPLL_ASSERT(label, c, r, prop, msg)
`define CPLL_ASSERT_NEXT(label, c, r, cond, conseq, msg)
`endif

`endif

// ===== rtl/core/cpll_pkg.sv =====
// Shared types and constants of the clamped piecewise-linear lookup unit.
// Used by the controller, the datapath and the top level; no dependencies.
package cpll_pkg;

    // Field widths of the breakpoint and result items.
    localparam int TIME_W   = 32;
    localparam int STRESS_W = 32;
    localparam int LAYER_W  = 16;
    localparam int DEPTH_W  = 32;
    localparam int CFG_W    = 7;
    localparam int STATUS_W = 2;

    // Smallest usable table.
    localparam int MIN_POINTS = 2;

    // The restoring divider produces one quotient bit per step.
    localparam int DIV_STEPS = STRESS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Operation codes of a request.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_REJECT    = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One breakpoint as held in the table memory.
    typedef struct packed {
        logic [TIME_W-1:0]   tstamp;
        logic [STRESS_W-1:0] stress;
        logic [LAYER_W-1:0]  layer;
        logic [DEPTH_W-1:0]  depth;
    } entry_t;

    // Which table address the datapath reads.
    typedef enum logic [2:0] {
        RD_FIRST,
        RD_LAST,
        RD_MID,
        RD_LOWER,
        RD_UPPER
    } rd_sel_t;

    // Which value the result registers take.
    typedef enum logic [1:0] {
        RES_HOLD,
        RES_CODE,
        RES_ENTRY,
        RES_INTERP
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     cfg_write;
        logic     load_write;
        rd_sel_t  rd_sel;
        logic     search_init;
        logic     search_step;
        logic     take_lower;
        logic     take_upper;
        logic     mul_load;
        logic     div_step;
        res_sel_t res_sel;
        status_t  res_code;
        logic     out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic table_full;
        logic load_bad;
        logic st_le_rd;
        logic st_ge_rd;
        logic search_cont;
    } dp_stat_t;

endpackage

// ===== rtl/core/cpll_ctrl.sv =====
// Controller of the lookup unit: sequences loads, clamping checks, the search,
// the multiply and the divide. Depends on cpll_pkg and the assertion macros.
`include "clamped_piecewise_linear_lookup_unit_macros.svh"

module cpll_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  cpll_pkg::dp_stat_t stat,
    output cpll_pkg::dp_cmd_t  cmd
);
    import cpll_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SEARCH,
        S_SEARCH_CMP,
        S_TAKE_LOWER,
        S_TAKE_UPPER,
        S_MUL,
        S_DIV,
        S_RESULT,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_next;

    // A new request or a register write is only taken while nothing is in progress.
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_FIRST;
        cmd.res_sel    = RES_HOLD;
        cmd.res_code   = ST_OK;
        cmd.cfg_write  = cfg_valid && cfg_ready;
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_sel = RES_CODE;
                state_next  = S_FINISH;
                if (stat.is_load)
                begin
                    if (stat.table_full)
                    begin
                        cmd.res_code = ST_FULL;
                    end
                    else if (stat.load_bad)
                    begin
                        cmd.res_code = ST_REJECT;
                    end
                    else
                    begin
                        cmd.res_code   = ST_OK;
                        cmd.load_write = 1'b1;
                    end
                end
                else if (!stat.table_full)
                begin
                    cmd.res_code = ST_NOT_READY;
                end
                else
                begin
                    // Table complete: fetch the first breakpoint for the low clamp.
                    cmd.res_sel = RES_HOLD;
                    cmd.rd_sel  = RD_FIRST;
                    state_next  = S_CHK_FIRST;
                end
            end
            S_CHK_FIRST:
            begin
                if (stat.st_le_rd)
                begin
                    cmd.res_sel = RES_ENTRY;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_LAST;
                    state_next = S_CHK_LAST;
                end
            end
            S_CHK_LAST:
            begin
                if (stat.st_ge_rd)
                begin
                    cmd.res_sel = RES_ENTRY;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.search_cont)
                begin
                    cmd.rd_sel = RD_MID;
                    state_next = S_SEARCH_CMP;
                end
                else
                begin
                    cmd.rd_sel = RD_LOWER;
                    state_next = S_TAKE_LOWER;
                end
            end
            S_SEARCH_CMP:
            begin
                // Narrow the bounds with the probe just read and issue the next read.
                cmd.search_step = 1'b1;
                if (stat.search_cont)
                begin
                    cmd.rd_sel = RD_MID;
                end
                else
                begin
                    cmd.rd_sel = RD_LOWER;
                    state_next = S_TAKE_LOWER;
                end
            end
            S_TAKE_LOWER:
            begin
                cmd.take_lower = 1'b1;
                cmd.rd_sel     = RD_UPPER;
                state_next     = S_TAKE_UPPER;
            end
            S_TAKE_UPPER:
            begin
                cmd.take_upper = 1'b1;
                state_next     = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                end
            end
            S_RESULT:
            begin
                cmd.res_sel = RES_INTERP;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register occupancy.
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    `CPLL_ASSERT(a_div_len, clk, rst_n, (state_reg == S_MUL) |-> ##(DIV_STEPS + 1) (state_reg == S_RESULT), "divider did not run its full step count")
    `CPLL_ASSERT_NEXT(a_single_accept, clk, rst_n, in_valid && !in_stall, in_stall, "request taken while another is in progress")
    `CPLL_ASSERT_NEXT(a_result_waits, clk, rst_n, (state_reg == S_FINISH) && out_valid_reg && out_stall, state_reg == S_FINISH, "pending result overwritten")

endmodule

// ===== rtl/core/cpll_dpath.sv =====
// Datapath of the lookup unit: breakpoint memory, search bounds, multiplier,
// restoring divider and result registers. Depends on cpll_pkg and the macros.
`include "clamped_piecewise_linear_lookup_unit_macros.svh"

module cpll_dpath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cpll_pkg::dp_cmd_t             cmd,
    output cpll_pkg::dp_stat_t            stat,
    input  logic [cpll_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          op,
    input  logic [cpll_pkg::TIME_W-1:0]   point_time,
    input  logic [cpll_pkg::STRESS_W-1:0] point_stress,
    input  logic [cpll_pkg::LAYER_W-1:0]  point_layer,
    input  logic [cpll_pkg::DEPTH_W-1:0]  point_depth,
    input  logic [cpll_pkg::TIME_W-1:0]   sample_time,
    output logic [cpll_pkg::STATUS_W-1:0] status,
    output logic [cpll_pkg::STRESS_W-1:0] stress,
    output logic [cpll_pkg::LAYER_W-1:0]  layer_code,
    output logic [cpll_pkg::DEPTH_W-1:0]  depth
);
    import cpll_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PROD_W = TIME_W + STRESS_W;

    // Breakpoint memory and its registered read port.
    entry_t                 entry_mem [MAX_POINTS];
    entry_t                 rd_data_reg;
    entry_t                 wr_entry;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;

    // Captured request.
    logic                   op_reg;
    logic [TIME_W-1:0]      pt_reg;
    logic [STRESS_W-1:0]    ps_reg;
    logic [LAYER_W-1:0]     pl_reg;
    logic [DEPTH_W-1:0]     pd_reg;
    logic [TIME_W-1:0]      st_reg;

    // Table occupancy.
    logic [CNT_W-1:0]       loaded_count_reg;
    logic [CNT_W-1:0]       loaded_count_next;
    logic [CNT_W-1:0]       point_count_reg;
    logic [CNT_W-1:0]       point_count_next;
    logic [TIME_W-1:0]      last_time_reg;
    logic [CNT_W-1:0]       last_cnt;
    logic [IDX_W-1:0]       last_idx;

    // Binary search bounds.
    logic [IDX_W-1:0]       lo_reg;
    logic [IDX_W-1:0]       hi_reg;
    logic [IDX_W-1:0]       mid_reg;
    logic [IDX_W-1:0]       lo_cur;
    logic [IDX_W-1:0]       hi_cur;
    logic [IDX_W-1:0]       mid_cur;

    // Bracketing pair and interpolation operands.
    logic [TIME_W-1:0]      tl_reg;
    logic [STRESS_W-1:0]    sl_reg;
    logic [LAYER_W-1:0]     ll_reg;
    logic [DEPTH_W-1:0]     dl_reg;
    logic [LAYER_W-1:0]     lu_reg;
    logic [DEPTH_W-1:0]     du_reg;
    logic [TIME_W-1:0]      off_reg;
    logic [TIME_W-1:0]      span_reg;
    logic [STRESS_W-1:0]    mag_reg;
    logic                   desc_reg;

    // Multiplier and divider.
    logic [PROD_W-1:0]      prod;
    logic [TIME_W-1:0]      rem_reg;
    logic [STRESS_W-1:0]    quo_reg;
    logic [TIME_W:0]        rem_ext;
    logic [TIME_W:0]        rem_diff;
    logic                   quo_bit;
    logic [STRESS_W-1:0]    interp_stress;

    // Result and output registers.
    status_t                res_status_reg;
    logic [STRESS_W-1:0]    res_stress_reg;
    logic [LAYER_W-1:0]     res_layer_reg;
    logic [DEPTH_W-1:0]     res_depth_reg;
    status_t                out_status_reg;
    logic [STRESS_W-1:0]    out_stress_reg;
    logic [LAYER_W-1:0]     out_layer_reg;
    logic [DEPTH_W-1:0]     out_depth_reg;

    assign last_cnt = loaded_count_reg - CNT_W'(1);
    assign last_idx = last_cnt[IDX_W-1:0];
    assign wr_addr  = loaded_count_reg[IDX_W-1:0];

    always_comb
    begin
        wr_entry.tstamp = pt_reg;
        wr_entry.stress = ps_reg;
        wr_entry.layer  = pl_reg;
        wr_entry.depth  = pd_reg;
    end

    // Status towards the controller.
    always_comb
    begin
        stat.is_load     = (op_reg == OP_LOAD);
        stat.table_full  = (loaded_count_reg >= point_count_reg);
        stat.load_bad    = (ps_reg == '0) ||
                           ((loaded_count_reg != '0) && (pt_reg <= last_time_reg));
        stat.st_le_rd    = (st_reg <= rd_data_reg.tstamp);
        stat.st_ge_rd    = (st_reg >= rd_data_reg.tstamp);
        stat.search_cont = (lo_cur < hi_cur);
    end

    // Search bounds after the probe that has just been read, and the next probe.
    always_comb
    begin
        lo_cur = lo_reg;
        hi_cur = hi_reg;
        if (cmd.search_step)
        begin
            if (rd_data_reg.tstamp > st_reg)
            begin
                hi_cur = mid_reg;
            end
            else
            begin
                lo_cur = mid_reg + IDX_W'(1);
            end
        end
        mid_cur = lo_cur + ((hi_cur - lo_cur) >> 1);
    end

    // Read address selection.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = last_idx;
            RD_MID:   rd_addr = mid_cur;
            RD_LOWER: rd_addr = lo_cur - IDX_W'(1);
            RD_UPPER: rd_addr = lo_reg;
            default:  rd_addr = '0;
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    // Point count saturation and table emptying on a register write.
    always_comb
    begin
        point_count_next  = point_count_reg;
        loaded_count_next = loaded_count_reg;
        if (cmd.cfg_write)
        begin
            if (cfg_data < CFG_W'(MIN_POINTS))
            begin
                point_count_next = CNT_W'(MIN_POINTS);
            end
            else if (32'(cfg_data) > 32'(MAX_POINTS))
            begin
                point_count_next = CNT_W'(MAX_POINTS);
            end
            else
            begin
                point_count_next = CNT_W'(cfg_data);
            end
            loaded_count_next = '0;
        end
        else if (cmd.load_write)
        begin
            loaded_count_next = loaded_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= CNT_W'(MIN_POINTS);
            loaded_count_reg <= '0;
        end
        else
        begin
            point_count_reg  <= point_count_next;
            loaded_count_reg <= loaded_count_next;
        end
    end

    // Divider step: shift in one dividend bit and subtract the span if it fits.
    assign prod          = PROD_W'(off_reg) * PROD_W'(mag_reg);
    assign rem_ext       = {rem_reg, quo_reg[STRESS_W-1]};
    assign rem_diff      = rem_ext - {1'b0, span_reg};
    assign quo_bit       = !rem_diff[TIME_W];
    assign interp_stress = desc_reg ? (sl_reg - quo_reg) : (sl_reg + quo_reg);

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            pt_reg <= point_time;
            ps_reg <= point_stress;
            pl_reg <= point_layer;
            pd_reg <= point_depth;
            st_reg <= sample_time;
        end

        if (cmd.load_write)
        begin
            last_time_reg <= pt_reg;
        end

        if (cmd.search_init)
        begin
            lo_reg <= IDX_W'(1);
            hi_reg <= last_idx;
        end
        else if (cmd.search_step)
        begin
            lo_reg <= lo_cur;
            hi_reg <= hi_cur;
        end
        if (cmd.rd_sel == RD_MID)
        begin
            mid_reg <= mid_cur;
        end

        if (cmd.take_lower)
        begin
            tl_reg <= rd_data_reg.tstamp;
            sl_reg <= rd_data_reg.stress;
            ll_reg <= rd_data_reg.layer;
            dl_reg <= rd_data_reg.depth;
        end

        // Offset, span and stress difference magnitude from the upper entry.
        if (cmd.take_upper)
        begin
            off_reg  <= st_reg - tl_reg;
            span_reg <= rd_data_reg.tstamp - tl_reg;
            desc_reg <= (rd_data_reg.stress < sl_reg);
            mag_reg  <= (rd_data_reg.stress < sl_reg) ? (sl_reg - rd_data_reg.stress)
                                                      : (rd_data_reg.stress - sl_reg);
            lu_reg   <= rd_data_reg.layer;
            du_reg   <= rd_data_reg.depth;
        end

        if (cmd.mul_load)
        begin
            rem_reg <= prod[PROD_W-1:STRESS_W];
            quo_reg <= prod[STRESS_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= quo_bit ? rem_diff[TIME_W-1:0] : rem_ext[TIME_W-1:0];
            quo_reg <= {quo_reg[STRESS_W-2:0], quo_bit};
        end

        case (cmd.res_sel)
            RES_CODE:
            begin
                res_status_reg <= cmd.res_code;
                res_stress_reg <= '0;
                res_layer_reg  <= '0;
                res_depth_reg  <= '0;
            end
            RES_ENTRY:
            begin
                res_status_reg <= ST_OK;
                res_stress_reg <= rd_data_reg.stress;
                res_layer_reg  <= rd_data_reg.layer;
                res_depth_reg  <= rd_data_reg.depth;
            end
            RES_INTERP:
            begin
                res_status_reg <= ST_OK;
                res_stress_reg <= interp_stress;
                res_layer_reg  <= (ll_reg != '0) ? ll_reg : lu_reg;
                res_depth_reg  <= (dl_reg != '0) ? dl_reg : du_reg;
            end
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_stress_reg <= res_stress_reg;
            out_layer_reg  <= res_layer_reg;
            out_depth_reg  <= res_depth_reg;
        end
    end

    assign status     = out_status_reg;
    assign stress     = out_stress_reg;
    assign layer_code = out_layer_reg;
    assign depth      = out_depth_reg;

    `CPLL_ASSERT(a_count_bound, clk, rst_n, loaded_count_reg <= point_count_reg, "more breakpoints loaded than the table allows")
    `CPLL_ASSERT(a_search_order, clk, rst_n, cmd.search_step |-> ((lo_cur <= hi_cur) && (lo_cur != '0)), "search bounds crossed or left the bracket range")
    `CPLL_ASSERT(a_rem_bound, clk, rst_n, cmd.div_step |-> (rem_reg < span_reg), "divider remainder not below the span")

endmodule

// ===== rtl/core/clamped_piecewise_linear_lookup_unit.sv =====
// Top level of the clamped piecewise-linear lookup unit.
// Instantiates cpll_ctrl and cpll_dpath; depends on cpll_pkg.
//
// One request is worked on at a time; the result register lets the next request
// be taken while a finished result still waits on out_stall. Loads and samples
// of an incomplete table are answered from the decode step, samples clamped to
// the first or last breakpoint after reading one or both ends, and interpolated
// samples after a binary search of at most ceil(log2(point_count - 1)) probes,
// the multiply and the divide; the next request can be taken in the cycle after
// the result enters the output register. The interpolation time is set by the
// 32-step restoring divider, the search by the single read port of the
// breakpoint memory. There is no clearing pass after reset: writing point_count
// empties the table at once, and register writes are taken only when idle.
module clamped_piecewise_linear_lookup_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpll_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [cpll_pkg::TIME_W-1:0]   point_time,
    input  logic [cpll_pkg::STRESS_W-1:0] point_stress,
    input  logic [cpll_pkg::LAYER_W-1:0]  point_layer,
    input  logic [cpll_pkg::DEPTH_W-1:0]  point_depth,
    input  logic [cpll_pkg::TIME_W-1:0]   sample_time,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cpll_pkg::STATUS_W-1:0] status,
    output logic [cpll_pkg::STRESS_W-1:0] stress,
    output logic [cpll_pkg::LAYER_W-1:0]  layer_code,
    output logic [cpll_pkg::DEPTH_W-1:0]  depth
);
    import cpll_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer for requests and register writes.
    cpll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, search, interpolation arithmetic and result registers.
    cpll_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_data     (cfg_data),
        .op           (op),
        .point_time   (point_time),
        .point_stress (point_stress),
        .point_layer  (point_layer),
        .point_depth  (point_depth),
        .sample_time  (sample_time),
        .status       (status),
        .stress       (stress),
        .layer_code   (layer_code),
        .depth        (depth)
    );

endmodule
